/* sv/cubic_bezier_point_eval_assert.svh */
// Assertion macros for the cubic Bezier point evaluator checker.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef CUBIC_BEZIER_POINT_EVAL_ASSERT_SVH
`define CUBIC_BEZIER_POINT_EVAL_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define CBZ_ASSERT_NOW(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cbz assertion failed");

// The trigger at one edge implies the consequence at the next edge.
`define CBZ_ASSERT_STEP(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("cbz assertion failed");

`endif

/* sv/cbz_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and the pipeline control struct of the Bezier evaluator.
// No dependencies; cbz_weight, cbz_axis, the top level and cbz_checker import this package.
package cbz_pkg;

    localparam int NUM_STAGES = 7;
    localparam int NUM_PTS    = 4;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } cbz_ctl_t;

endpackage

/* sv/cbz_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the Bezier evaluator input and result items.
// No dependencies.
interface cbz_in_if #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] p0_x;
    logic signed [COORD_WIDTH-1:0] p0_y;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic signed [COORD_WIDTH-1:0] p3_x;
    logic signed [COORD_WIDTH-1:0] p3_y;
    logic        [T_FRAC_BITS:0]   t_param;

    modport source (
        output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, t_param,
        input  ready
    );
    modport sink (
        input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, t_param,
        output ready
    );
endinterface

interface cbz_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;

    modport source (
        output valid, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y,
        output ready
    );
endinterface

/* sv/cbz_weight.sv */
`timescale 1ns / 1ps
// Bernstein weight generator: clamps t and forms the four cubic weights in two stages.
// Depends on cbz_pkg for the pipeline control struct.
module cbz_weight
    import cbz_pkg::*;
#(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  cbz_ctl_t                            ctl,
    input  logic [T_FRAC_BITS:0]                t_param,
    output logic [NUM_PTS-1:0][T_FRAC_BITS+1:0] weights
);

    localparam int F  = T_FRAC_BITS;
    localparam int TW = F + 1;
    localparam int WW = F + 2;
    localparam int PW = 2 * F + 2;
    localparam int XW = 2 * F + 4;

    localparam logic [TW-1:0] T_ONE  = {1'b1, {F{1'b0}}};
    localparam logic [PW-1:0] HALF_P = PW'(1) << (F - 1);
    localparam logic [XW-1:0] HALF_X = XW'(1) << (F - 1);

    logic [TW-1:0] t_cl;
    logic [TW-1:0] s_val;
    logic [PW-1:0] sq_s;
    logic [PW-1:0] sq_t;
    logic [TW-1:0] t_reg, s_reg, ss_reg, tt_reg;
    logic [TW-1:0] ss_next, tt_next;

    logic [PW-1:0] m0, m1, m2, m3;
    logic [XW-1:0] x0, x1, x2, x3;
    logic [NUM_PTS-1:0][WW-1:0] w_next;
    logic [NUM_PTS-1:0][WW-1:0] w_reg;

    always_comb
    begin
        t_cl    = (t_param > T_ONE) ? T_ONE : t_param;
        s_val   = T_ONE - t_cl;
        sq_s    = PW'(s_val) * PW'(s_val) + HALF_P;
        sq_t    = PW'(t_cl) * PW'(t_cl) + HALF_P;
        ss_next = sq_s[F +: TW];
        tt_next = sq_t[F +: TW];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            t_reg  <= t_cl;
            s_reg  <= s_val;
            ss_reg <= ss_next;
            tt_reg <= tt_next;
        end
    end

    always_comb
    begin
        m0 = PW'(ss_reg) * PW'(s_reg);
        m1 = PW'(ss_reg) * PW'(t_reg);
        m2 = PW'(s_reg) * PW'(tt_reg);
        m3 = PW'(tt_reg) * PW'(t_reg);
        x0 = {2'b00, m0} + HALF_X;
        x1 = {2'b00, m1} + {1'b0, m1, 1'b0} + HALF_X;
        x2 = {2'b00, m2} + {1'b0, m2, 1'b0} + HALF_X;
        x3 = {2'b00, m3} + HALF_X;
        w_next[0] = x0[F +: WW];
        w_next[1] = x1[F +: WW];
        w_next[2] = x2[F +: WW];
        w_next[3] = x3[F +: WW];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            w_reg <= w_next;
        end
    end

    assign weights = w_reg;

endmodule

/* sv/cbz_axis.sv */
`timescale 1ns / 1ps
// One coordinate axis: split multiplies, term assembly, adder tree, rounding, saturation.
// Depends on cbz_pkg; takes its weights from cbz_weight.
module cbz_axis
    import cbz_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                        clk,
    input  cbz_ctl_t                                    ctl,
    input  logic [NUM_PTS-1:0][COORD_WIDTH-1:0]         pts,
    input  logic [NUM_PTS-1:0][T_FRAC_BITS+1:0]         weights,
    output logic signed [COORD_WIDTH-1:0]               point
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = T_FRAC_BITS;
    localparam int WW  = F + 2;
    localparam int H   = CW / 2;
    localparam int HW  = CW - H;
    localparam int LPW = H + WW;
    localparam int HPW = HW + WW + 1;
    localparam int AW  = CW + WW + 2;
    localparam int SW  = AW - F;

    localparam logic signed [AW-1:0] HALF_A = AW'(1) << (F - 1);
    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    logic [NUM_PTS-1:0][CW-1:0]         p1_reg, p2_reg;
    logic [NUM_PTS-1:0][LPW-1:0]        lo_next, lo_reg;
    logic [NUM_PTS-1:0][HPW-1:0]        hi_next, hi_reg;
    logic [NUM_PTS-1:0][AW-1:0]         term_next, term_reg;
    logic [1:0][AW-1:0]                 pair_reg;
    logic signed [AW-1:0]               tot_reg;
    logic signed [SW-1:0]               shifted;
    logic signed [CW-1:0]               point_next;
    logic signed [CW-1:0]               point_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            p1_reg <= pts;
        end
        if (ctl.load[1])
        begin
            p2_reg <= p1_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_PTS; i++)
        begin
            lo_next[i] = LPW'(p2_reg[i][H-1:0]) * LPW'(weights[i]);
            hi_next[i] = HPW'($signed(p2_reg[i][CW-1:H]))
                       * HPW'($signed({1'b0, weights[i]}));
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_PTS; i++)
        begin
            term_next[i] = ({{(AW-HPW){hi_reg[i][HPW-1]}}, hi_reg[i]} << H)
                         + {{(AW-LPW){1'b0}}, lo_reg[i]};
        end
    end

    always_comb
    begin
        shifted = $signed(tot_reg[AW-1:F]);
        if (shifted > SAT_MAX)
        begin
            point_next = SAT_MAX[CW-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            point_next = SAT_MIN[CW-1:0];
        end
        else
        begin
            point_next = shifted[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (ctl.load[3])
        begin
            term_reg <= term_next;
        end
        if (ctl.load[4])
        begin
            pair_reg[0] <= term_reg[0] + term_reg[1];
            pair_reg[1] <= term_reg[2] + term_reg[3];
        end
        if (ctl.load[5])
        begin
            tot_reg <= $signed(pair_reg[0]) + $signed(pair_reg[1]) + HALF_A;
        end
        if (ctl.load[6])
        begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

/* sv/cubic_bezier_point_eval.sv */
`timescale 1ns / 1ps
// Top level of the 2D cubic Bezier point evaluator: valid chain and stage control.
// Depends on cbz_pkg, cbz_if, cbz_weight and cbz_axis.
//
//   Channel   Dir   Handshake       Payload
//   in_ch     in    valid / ready   p0..p3 x/y (signed), t_param (unsigned)
//   out_ch    out   valid / ready   point_x, point_y (signed, saturated)
//
// One item per cycle is accepted unless an output stall has backed up through every stage.
// The seven stages are weight squaring, weight cubing, split coordinate multiply,
// term assembly, two adder levels with rounding, and saturation into the output register.
// A stage holds while its successor is full and stalled, so empty stages still fill.
// Reset clears only the stage valid bits.
module cubic_bezier_point_eval
    import cbz_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    cbz_in_if.sink    in_ch,
    cbz_out_if.source out_ch
);

    localparam int LAST = NUM_STAGES - 1;

    cbz_ctl_t                                ctl;
    logic [NUM_STAGES-1:0]                   valid_reg;
    logic [NUM_STAGES-1:0]                   valid_next;
    logic [NUM_PTS-1:0][T_FRAC_BITS+1:0]     weights;
    logic [NUM_PTS-1:0][COORD_WIDTH-1:0]     pts_x;
    logic [NUM_PTS-1:0][COORD_WIDTH-1:0]     pts_y;
    logic signed [COORD_WIDTH-1:0]           point_x;
    logic signed [COORD_WIDTH-1:0]           point_y;

    always_comb
    begin
        ctl.load[LAST] = !valid_reg[LAST] || out_ch.ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            ctl.load[k] = !valid_reg[k] || ctl.load[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.load[0])
        begin
            valid_next[0] = in_ch.valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (ctl.load[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pts_x = {in_ch.p3_x, in_ch.p2_x, in_ch.p1_x, in_ch.p0_x};
    assign pts_y = {in_ch.p3_y, in_ch.p2_y, in_ch.p1_y, in_ch.p0_y};

    cbz_weight #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_weight (
        .clk     (clk),
        .ctl     (ctl),
        .t_param (in_ch.t_param),
        .weights (weights)
    );

    cbz_axis #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_x (
        .clk     (clk),
        .ctl     (ctl),
        .pts     (pts_x),
        .weights (weights),
        .point   (point_x)
    );

    cbz_axis #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_y (
        .clk     (clk),
        .ctl     (ctl),
        .pts     (pts_y),
        .weights (weights),
        .point   (point_y)
    );

    assign in_ch.ready    = ctl.load[0];
    assign out_ch.valid   = valid_reg[LAST];
    assign out_ch.point_x = point_x;
    assign out_ch.point_y = point_y;

endmodule

/* sv/cbz_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the Bezier evaluator, bound to the top level.
// Depends on cbz_pkg and the macros in cubic_bezier_point_eval_assert.svh.
`include "cubic_bezier_point_eval_assert.svh"

module cbz_checker
    import cbz_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [COORD_WIDTH-1:0] point_x,
    input logic [COORD_WIDTH-1:0] point_y
);

    localparam int CNT_W = $clog2(NUM_STAGES + 1) + 1;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && in_ready)
        begin
            cnt_next = cnt_next + CNT_W'(1);
        end
        if (out_valid && out_ready)
        begin
            cnt_next = cnt_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `CBZ_ASSERT_STEP(a_out_valid_hold, out_valid && !out_ready, out_valid)
    `CBZ_ASSERT_STEP(a_out_data_hold, out_valid && !out_ready, $stable(point_x) && $stable(point_y))
    `CBZ_ASSERT_NOW(a_depth_bound, cnt_reg <= CNT_W'(NUM_STAGES))
    `CBZ_ASSERT_NOW(a_no_phantom, !out_valid || (cnt_reg != '0))

endmodule

bind cubic_bezier_point_eval cbz_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_cbz_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .point_x   (out_ch.point_x),
    .point_y   (out_ch.point_y)
);

/* tb/cbz_point_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the cubic Bezier point evaluator: predicts the curve point of each
// accepted input item and compares it, in order, with the result items.
// Depends on cbz_in_if and cbz_out_if; instantiated by tb_top beside the block.
module cbz_point_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    cbz_in_if    in_ch,
    cbz_out_if   out_ch,
    output int   mismatches,
    output int   points_due,
    output int   points_seen
);

    localparam longint T_ONE       = longint'(1) << T_FRAC_BITS;
    localparam longint T_HALF      = longint'(1) << (T_FRAC_BITS - 1);
    localparam longint C_MAX       = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint C_MIN       = -(longint'(1) << (COORD_WIDTH - 1));
    localparam int     ACC_W       = COORD_WIDTH + T_FRAC_BITS + 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } curve_point_t;

    curve_point_t expected_points[$];

    function automatic coord_t blend_axis(input coord_t c0, c1, c2, c3,
                                          input longint w0, w1, w2, w3);
        acc_t acc;
        acc = acc_t'(c0) * acc_t'(w0) + acc_t'(c1) * acc_t'(w1)
            + acc_t'(c2) * acc_t'(w2) + acc_t'(c3) * acc_t'(w3) + acc_t'(T_HALF);
        acc = acc >>> T_FRAC_BITS;
        if (acc > acc_t'(C_MAX))
            return coord_t'(C_MAX);
        if (acc < acc_t'(C_MIN))
            return coord_t'(C_MIN);
        return coord_t'(acc);
    endfunction

    task automatic flag_field(input string field, input coord_t want_v, input coord_t got_v);
        mismatches++;
        $display("%0t ns: point %0d %s expected %0d (0x%h), got %0d (0x%h)",
                 $time, points_seen, field, want_v, want_v, got_v, got_v);
    endtask

    always @(posedge clk) begin
        longint       t_c;
        longint       s;
        longint       ss;
        longint       tt;
        longint       w0;
        longint       w1;
        longint       w2;
        longint       w3;
        curve_point_t want;
        curve_point_t got;
        if (!rst_n)
        begin
            expected_points.delete();
            mismatches  = 0;
            points_due  = 0;
            points_seen = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                points_seen++;
                got.x = out_ch.point_x;
                got.y = out_ch.point_y;
                if (expected_points.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result item with no input item pending: x %0d, y %0d",
                             $time, got.x, got.y);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.x !== want.x)
                        flag_field("x", want.x, got.x);
                    if (got.y !== want.y)
                        flag_field("y", want.y, got.y);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                t_c = longint'(in_ch.t_param);
                if (t_c > T_ONE)
                    t_c = T_ONE;
                s  = T_ONE - t_c;
                ss = (s * s + T_HALF) >> T_FRAC_BITS;
                tt = (t_c * t_c + T_HALF) >> T_FRAC_BITS;
                w0 = (ss * s + T_HALF) >> T_FRAC_BITS;
                w1 = (3 * ss * t_c + T_HALF) >> T_FRAC_BITS;
                w2 = (3 * s * tt + T_HALF) >> T_FRAC_BITS;
                w3 = (tt * t_c + T_HALF) >> T_FRAC_BITS;
                want.x = blend_axis(in_ch.p0_x, in_ch.p1_x, in_ch.p2_x, in_ch.p3_x,
                                    w0, w1, w2, w3);
                want.y = blend_axis(in_ch.p0_y, in_ch.p1_y, in_ch.p2_y, in_ch.p3_y,
                                    w0, w1, w2, w3);
                expected_points.push_back(want);
            end
            points_due = expected_points.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the cubic Bezier point evaluator: clock, reset, curve sample
// stimulus with bursty input and a stalling output, and the final verdict.
// Depends on cbz_if, cubic_bezier_point_eval and cbz_point_checker.
module tb_top;

    localparam int COORD_WIDTH    = 32;
    localparam int T_FRAC_BITS    = 16;
    localparam int T_ONE          = 1 << T_FRAC_BITS;
    localparam int RANDOM_SAMPLES = 1030;
    localparam int HOLD_CYCLES    = 60;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [T_FRAC_BITS:0]          tparam_t;
    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_RARE, RX_PERIODIC} rx_mode_t;

    localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic clk = 1'b0;
    logic rst_n;
    int   items_sent;
    int   burst_left;
    int   mismatches;
    int   points_due;
    int   points_seen;

    cbz_in_if #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) in_ch ();
    cbz_out_if #(.COORD_WIDTH(COORD_WIDTH)) out_ch ();

    cubic_bezier_point_eval #(
        .COORD_WIDTH(COORD_WIDTH),
        .T_FRAC_BITS(T_FRAC_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    cbz_point_checker #(
        .COORD_WIDTH(COORD_WIDTH),
        .T_FRAC_BITS(T_FRAC_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .mismatches (mismatches),
        .points_due (points_due),
        .points_seen(points_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic coord_t any_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return coord_t'($urandom);
            4, 5, 6:    return coord_t'($signed($urandom) >>> $urandom_range(4, 28));
            7:
            begin
                case ($urandom_range(0, 6))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return coord_t'(0);
                    3: return coord_t'(-1);
                    4: return coord_t'(1);
                    5: return coord_t'(65536);
                    default: return coord_t'(-65536);
                endcase
            end
            default: return coord_t'(int'($urandom_range(0, 2000)) - 1000) <<< 16;
        endcase
    endfunction

    function automatic tparam_t any_t();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return tparam_t'($urandom_range(0, T_ONE));
            5:
            begin
                case ($urandom_range(0, 3))
                    0: return tparam_t'(0);
                    1: return tparam_t'(1);
                    2: return tparam_t'(T_ONE - 1);
                    default: return tparam_t'(T_ONE);
                endcase
            end
            6: return tparam_t'($urandom_range(T_ONE + 1, 2 * T_ONE - 1));
            7: return tparam_t'($urandom_range(0, 255));
            8: return tparam_t'(T_ONE - int'($urandom_range(0, 255)));
            default: return tparam_t'($urandom);
        endcase
    endfunction

    task automatic offer(input coord_t p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y,
                         input tparam_t t);
        @(negedge clk);
        in_ch.p0_x    = p0x;
        in_ch.p0_y    = p0y;
        in_ch.p1_x    = p1x;
        in_ch.p1_y    = p1y;
        in_ch.p2_x    = p2x;
        in_ch.p2_y    = p2y;
        in_ch.p3_x    = p3x;
        in_ch.p3_y    = p3y;
        in_ch.t_param = t;
        in_ch.valid   = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
            repeat ($urandom_range(1, 5))
            begin
                @(negedge clk);
                in_ch.valid   = 1'b0;
                in_ch.t_param = tparam_t'($urandom);
            end
        end
    endtask

    initial
    begin
        coord_t  curve [8];
        int      seg_len;
        int      n;
        bit      sweep;
        tparam_t t;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.p0_x    = '0;
        in_ch.p0_y    = '0;
        in_ch.p1_x    = '0;
        in_ch.p1_y    = '0;
        in_ch.p2_x    = '0;
        in_ch.p2_y    = '0;
        in_ch.p3_x    = '0;
        in_ch.p3_y    = '0;
        in_ch.t_param = '0;
        items_sent    = 0;
        burst_left    = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // The end values must give the end points exactly, and t above one is clamped.
        offer(0, 0, 0, 0, 0, 0, 0, 0, 0);
        offer(32'h0001_0000, -32'h0002_0000, 32'h0012_3456, -32'h00AB_CDEF,
              -32'h0345_6789, 32'h0FED_CBA9, 32'h7654_3210, -32'h1234_5678, 0);
        offer(32'h0001_0000, -32'h0002_0000, 32'h0012_3456, -32'h00AB_CDEF,
              -32'h0345_6789, 32'h0FED_CBA9, 32'h7654_3210, -32'h1234_5678, T_ONE);
        offer(32'h0001_0000, -32'h0002_0000, 32'h0012_3456, -32'h00AB_CDEF,
              -32'h0345_6789, 32'h0FED_CBA9, 32'h7654_3210, -32'h1234_5678, T_ONE + 1);
        offer(32'h0001_0000, -32'h0002_0000, 32'h0012_3456, -32'h00AB_CDEF,
              -32'h0345_6789, 32'h0FED_CBA9, 32'h7654_3210, -32'h1234_5678, 17'h1FFFF);
        offer(32'h0001_0000, -32'h0002_0000, 32'h0012_3456, -32'h00AB_CDEF,
              -32'h0345_6789, 32'h0FED_CBA9, 32'h7654_3210, -32'h1234_5678, T_ONE / 2);
        offer(32'h0001_0000, -32'h0002_0000, 32'h0012_3456, -32'h00AB_CDEF,
              -32'h0345_6789, 32'h0FED_CBA9, 32'h7654_3210, -32'h1234_5678, 1);
        offer(32'h0001_0000, -32'h0002_0000, 32'h0012_3456, -32'h00AB_CDEF,
              -32'h0345_6789, 32'h0FED_CBA9, 32'h7654_3210, -32'h1234_5678, T_ONE - 1);
        offer(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0);
        offer(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, T_ONE / 2);
        offer(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, T_ONE / 3);
        offer(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, T_ONE);
        offer(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, T_ONE / 2);
        offer(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, T_ONE / 3);
        offer(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, T_ONE / 2);
        offer(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, T_ONE / 4);
        offer(-1, -1, -1, -1, -1, -1, -1, -1, T_ONE / 2);
        offer(1, 1, 1, 1, 1, 1, 1, 1, 12345);
        offer(0, 0, C_MAX, 0, 0, C_MIN, 0, 0, T_ONE / 3);
        offer(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, T_ONE + 1000);
        repeat (4)
            offer(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, any_t());

        // Random curves, either swept in t as in tessellation or sampled at random t.
        n = 0;
        while (n < RANDOM_SAMPLES)
        begin
            foreach (curve[i])
                curve[i] = any_coord();
            seg_len = $urandom_range(1, 24);
            sweep   = $urandom_range(0, 1);
            for (int k = 0; k < seg_len && n < RANDOM_SAMPLES; k++)
            begin
                if (sweep)
                    t = tparam_t'((k * T_ONE) / ((seg_len > 1) ? seg_len - 1 : 1));
                else
                    t = any_t();
                offer(curve[0], curve[1], curve[2], curve[3],
                      curve[4], curve[5], curve[6], curve[7], t);
                n++;
            end
        end
        @(negedge clk);
        in_ch.valid = 1'b0;

        while (points_due != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        $display("Run covered %0d curve samples: end values, t clamping, saturation,",
                 items_sent);
        $display("t sweeps and random curves; %0d points compared under output stalls.",
                 points_seen);
        if (mismatches == 0)
            $display("[cubic_bezier_point_eval] OK");
        else
            $display("[cubic_bezier_point_eval] ERROR");
        $finish;
    end

    initial
    begin
        rx_mode_t mode;
        int       seg;
        int       next_hold;
        out_ch.ready = 1'b0;
        next_hold    = 300;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            seg  = $urandom_range(10, 150);
            for (int k = 0; k < seg; k++)
            begin
                @(negedge clk);
                if (items_sent >= next_hold)
                begin
                    next_hold    += 400;
                    out_ch.ready = 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge clk);
                end
                case (mode)
                    RX_ALWAYS:   out_ch.ready = 1'b1;
                    RX_COIN:     out_ch.ready = $urandom_range(0, 1);
                    RX_RARE:     out_ch.ready = ($urandom_range(0, 9) != 0);
                    RX_PERIODIC: out_ch.ready = ((k % 4) != 3);
                endcase
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("[cubic_bezier_point_eval] ERROR");
        $finish;
    end

endmodule
